### hdl/mlqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants of the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_RAN     = 2'd1;
   localparam logic [1:0] STATUS_ACCEPT  = 2'd2;
   localparam logic [1:0] STATUS_DROP    = 2'd3;

   localparam logic [1:0] LEVEL_HIGH   = 2'd0;
   localparam logic [1:0] LEVEL_MIDDLE = 2'd1;
   localparam logic [1:0] LEVEL_LOW    = 2'd2;

   localparam logic       CMD_TICK   = 1'b0;
   localparam logic       CMD_ARRIVE = 1'b1;

   localparam logic [3:0] HIGH_QUOTA_RESET   = 4'd6;
   localparam logic [3:0] MIDDLE_QUOTA_RESET = 4'd4;

   localparam logic [0:0] CSR_HIGH_QUOTA   = 1'd0;
   localparam logic [0:0] CSR_MIDDLE_QUOTA = 1'd1;

   typedef struct packed {
      logic       cmd;
      logic [9:0] job_tag;
      logic [1:0] level;
      logic [3:0] prio;
      logic [7:0] svc_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  ran_tag;
      logic [1:0]  ran_level;
      logic        finished;
      logic [15:0] done_tick;
      logic [15:0] turnaround;
      logic [15:0] wait_ticks;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SHIFT,
      ST_OUT
   } state_type;

endpackage

### hdl/multilevel_queue_scheduler.sv
`timescale 1ns / 1ps
// Order: an arrival or an idle tick presents its result in the cycle after
// acceptance; a tick with jobs queued scans the chosen queue, then updates
// the chosen job and, when the job completes, closes the gap in its queue
// before the result is given, all through the one shared memory.
// Flow: one transaction at a time; a new one is taken only when idle and no result is pending.
// Reset: synchronous; queues empty, time zero, quotas and credits at 6 and 4.
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler
// Three-class job scheduler; each class queue lives in one shared memory.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler
   import mlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [3:0] csr_wdata
);

   localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ADR_BITS = IDX_BITS + 2;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef struct packed {
      logic [9:0]           tag;
      logic [3:0]           prio;
      logic [7:0]           service;
      logic [7:0]           remain;
      logic [TIME_BITS-1:0] arrival;
   } entry_type;

   entry_type mem [1 << ADR_BITS];
   entry_type rd_data_ff;
   logic              mem_we;
   logic [ADR_BITS-1:0] mem_waddr, mem_raddr;
   entry_type         mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff [3];
   logic [CNT_BITS-1:0] cnt_in [3];
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [3:0] hq_ff, mq_ff, hc_ff, mc_ff, hc_in, mc_in;
   logic [1:0] sel_ff, sel_in;
   logic [CNT_BITS-1:0] ptr_ff, ptr_in;       // read address issued
   logic [IDX_BITS-1:0] best_ff, best_in;
   entry_type best_e_ff, best_e_in;
   logic [IDX_BITS-1:0] sh_ff, sh_in;         // gap-closing position
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0] cur_cnt;
   logic better;
   logic [TIME_BITS-1:0] done_t;
   logic [TIME_BITS:0]   turn_t;
   logic [TIME_BITS:0]   wait_t;

   assign cur_cnt = cnt_ff[sel_ff];

   always_comb begin
      case (sel_ff)
         LEVEL_HIGH:   better = rd_data_ff.prio < best_e_ff.prio;
         LEVEL_MIDDLE: better = rd_data_ff.service < best_e_ff.service;
         default:      better = rd_data_ff.arrival < best_e_ff.arrival;
      endcase
   end

   // the tick count has already advanced, so it is the completion time
   assign done_t = now_ff;
   assign turn_t = {1'b0, done_t} - {1'b0, best_e_ff.arrival};
   assign wait_t = turn_t[TIME_BITS] ? '0 :
                   ((turn_t >= (TIME_BITS+1)'(best_e_ff.service)) ?
                    turn_t - (TIME_BITS+1)'(best_e_ff.service) : '0);

   function automatic logic [15:0] sat16(input logic [TIME_BITS:0] v);
      logic [TIME_BITS+16:0] w;
      w = (TIME_BITS+17)'(v);
      sat16 = (w > (TIME_BITS+17)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready && req_data.cmd == CMD_TICK) begin
               if (cnt_ff[0] != '0 || cnt_ff[1] != '0 || cnt_ff[2] != '0)
                  state_in = ST_SCAN;
            end
         end
         ST_SCAN:   if (ptr_ff >= cur_cnt) state_in = ST_UPDATE;
         ST_UPDATE: state_in = (best_e_ff.remain <= 8'd1) ? ST_SHIFT : ST_IDLE;
         ST_SHIFT: begin
            if (CNT_BITS'(sh_ff) + CNT_BITS'(2) >= cur_cnt) state_in = ST_OUT;
         end
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in = cnt_ff;
      now_in = now_ff;
      hc_in = hc_ff;
      mc_in = mc_ff;
      sel_in = sel_ff;
      ptr_in = ptr_ff;
      best_in = best_ff;
      best_e_in = best_e_ff;
      sh_in = sh_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = best_e_ff;
      mem_raddr = {sel_ff, ptr_ff[IDX_BITS-1:0]};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in = '0;
               rsp_valid_in = 1'b1;
               if (req_data.cmd == CMD_ARRIVE) begin
                  rsp_in.ran_tag = req_data.job_tag;
                  rsp_in.ran_level = req_data.level;
                  if (req_data.level == 2'd3 ||
                      cnt_ff[req_data.level] >= CNT_BITS'(QUEUE_DEPTH)) begin
                     rsp_in.status = STATUS_DROP;
                  end else begin
                     rsp_in.status = STATUS_ACCEPT;
                     mem_we = 1'b1;
                     mem_waddr = {req_data.level,
                                  cnt_ff[req_data.level][IDX_BITS-1:0]};
                     mem_wdata.tag = req_data.job_tag;
                     mem_wdata.prio = req_data.prio;
                     mem_wdata.service = req_data.svc_ticks;
                     mem_wdata.remain = req_data.svc_ticks;
                     mem_wdata.arrival = now_ff;
                     cnt_in[req_data.level] = cnt_ff[req_data.level] + 1'b1;
                  end
               end else begin
                  rsp_in.status = STATUS_IDLE;
                  if (cnt_ff[0] != '0 && cnt_ff[1] != '0) begin
                     if (hc_ff != '0) begin
                        sel_in = LEVEL_HIGH;
                        hc_in = hc_ff - 1'b1;
                     end else begin
                        sel_in = LEVEL_MIDDLE;
                        if (mc_ff <= 4'd1) begin
                           hc_in = hq_ff;
                           mc_in = mq_ff;
                        end else begin
                           mc_in = mc_ff - 1'b1;
                        end
                     end
                  end else if (cnt_ff[0] != '0) begin
                     sel_in = LEVEL_HIGH;
                     if (hc_ff != '0) hc_in = hc_ff - 1'b1;
                  end else if (cnt_ff[1] != '0) begin
                     sel_in = LEVEL_MIDDLE;
                  end else begin
                     sel_in = LEVEL_LOW;
                  end
                  // issue read of entry 0 for the scan
                  mem_raddr = {sel_in, {IDX_BITS{1'b0}}};
                  ptr_in = CNT_BITS'(1);
                  best_in = '0;
                  if (now_ff != TIME_MAX) now_in = now_ff + 1'b1;
                  if (cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0)
                     rsp_valid_in = 1'b1;
                  else
                     rsp_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // data for entry ptr-1 is available now
            if (ptr_ff == CNT_BITS'(1)) begin
               best_e_in = rd_data_ff;
               best_in = '0;
            end else if (better) begin
               best_e_in = rd_data_ff;
               best_in = IDX_BITS'(ptr_ff - 1'b1);
            end
            if (ptr_ff < cur_cnt) ptr_in = ptr_ff + 1'b1;
         end
         ST_UPDATE: begin
            rsp_in = '0;
            rsp_in.status = STATUS_RAN;
            rsp_in.ran_tag = best_e_ff.tag;
            rsp_in.ran_level = sel_ff;
            if (best_e_ff.remain <= 8'd1) begin
               rsp_in.finished = 1'b1;
               rsp_in.done_tick = sat16({1'b0, done_t});
               rsp_in.turnaround = sat16(turn_t[TIME_BITS] ? '0 : turn_t);
               rsp_in.wait_ticks = sat16(wait_t);
               sh_in = best_ff;
               mem_raddr = {sel_ff, IDX_BITS'(CNT_BITS'(best_ff) + 1'b1)};
            end else begin
               mem_we = 1'b1;
               mem_waddr = {sel_ff, best_ff};
               mem_wdata.remain = best_e_ff.remain - 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (CNT_BITS'(sh_ff) + CNT_BITS'(1) < cur_cnt) begin
               mem_we = 1'b1;
               mem_waddr = {sel_ff, sh_ff};
               mem_wdata = rd_data_ff;
            end
            sh_in = sh_ff + 1'b1;
            mem_raddr = {sel_ff, IDX_BITS'(CNT_BITS'(sh_ff) + CNT_BITS'(2))};
         end
         ST_OUT: begin
            cnt_in[sel_ff] = cur_cnt - 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         cnt_ff[2] <= '0;
         now_ff <= '0;
         hq_ff <= HIGH_QUOTA_RESET;
         mq_ff <= MIDDLE_QUOTA_RESET;
         hc_ff <= HIGH_QUOTA_RESET;
         mc_ff <= MIDDLE_QUOTA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         now_ff <= now_in;
         hc_ff <= hc_in;
         mc_ff <= mc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_HIGH_QUOTA:   hq_ff <= csr_wdata;
               CSR_MIDDLE_QUOTA: mq_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      ptr_ff <= ptr_in;
      best_ff <= best_in;
      best_e_ff <= best_e_in;
      sh_ff <= sh_in;
      rsp_ff <= rsp_in;
   end

endmodule

### tb/mlqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_checker
// Watches the job and result channels of the scheduler, keeps a shadow copy
// of its queues, credits and tick count, and compares every result in order.
// ----------------------------------------------------------------------------
module mlqs_checker
   import mlqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [3:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_count
);

   localparam int DEPTH = 16;

   typedef struct {
      logic [9:0]  tag;
      logic [3:0]  prio;
      logic [7:0]  service;
      logic [7:0]  remain;
      logic [15:0] arrival;
   } job_type;

   job_type     jobs [3][DEPTH];
   int          fill [3];
   logic [15:0] tick_count;
   logic [3:0]  high_credit, middle_credit, high_quota, middle_quota;
   rsp_type     expected_rsp [$];

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic int choose(input int lvl);
      int best;
      best = 0;
      for (int i = 1; i < fill[lvl]; i++) begin
         if (lvl == 0 && jobs[0][i].prio < jobs[0][best].prio) best = i;
         if (lvl == 1 && jobs[1][i].service < jobs[1][best].service) best = i;
         if (lvl == 2 && jobs[2][i].arrival < jobs[2][best].arrival) best = i;
      end
      return best;
   endfunction

   task automatic schedule(input req_type r);
      rsp_type     o;
      int          sel, idx;
      logic [15:0] done, turn;
      o = '0;
      if (r.cmd == CMD_ARRIVE) begin
         o.ran_tag = r.job_tag;
         o.ran_level = r.level;
         if (r.level > LEVEL_LOW || fill[r.level] >= DEPTH) begin
            o.status = STATUS_DROP;
         end else begin
            jobs[r.level][fill[r.level]] = '{r.job_tag, r.prio, r.svc_ticks,
                                             r.svc_ticks, tick_count};
            fill[r.level]++;
            o.status = STATUS_ACCEPT;
         end
      end else begin
         sel = -1;
         if (fill[0] > 0 && fill[1] > 0) begin
            if (high_credit > 0) begin
               sel = 0;
               high_credit--;
            end else begin
               sel = 1;
               if (middle_credit > 0) middle_credit--;
               if (middle_credit == 0) begin
                  high_credit = high_quota;
                  middle_credit = middle_quota;
               end
            end
         end else if (fill[0] > 0) begin
            sel = 0;
            if (high_credit > 0) high_credit--;
         end else if (fill[1] > 0) begin
            sel = 1;
         end else if (fill[2] > 0) begin
            sel = 2;
         end
         if (sel >= 0) begin
            idx = choose(sel);
            o.status = STATUS_RAN;
            o.ran_tag = jobs[sel][idx].tag;
            o.ran_level = 2'(sel);
            if (jobs[sel][idx].remain <= 1) begin
               done = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
               turn = (done >= jobs[sel][idx].arrival) ? done - jobs[sel][idx].arrival : '0;
               o.finished = 1'b1;
               o.done_tick = done;
               o.turnaround = turn;
               o.wait_ticks = (turn >= 16'(jobs[sel][idx].service)) ?
                              turn - 16'(jobs[sel][idx].service) : '0;
               for (int i = idx; i + 1 < fill[sel]; i++) jobs[sel][i] = jobs[sel][i + 1];
               fill[sel]--;
            end else begin
               jobs[sel][idx].remain--;
            end
         end
         if (tick_count != 16'hFFFF) tick_count++;
      end
      expected_rsp.push_back(o);
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         fill = '{0, 0, 0};
         tick_count = '0;
         high_quota = HIGH_QUOTA_RESET;
         middle_quota = MIDDLE_QUOTA_RESET;
         high_credit = HIGH_QUOTA_RESET;
         middle_credit = MIDDLE_QUOTA_RESET;
         expected_rsp.delete();
         mismatch_count = 0;
         pending_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_HIGH_QUOTA) high_quota = csr_wdata;
            else middle_quota = csr_wdata;
         end
         if (req_valid && req_ready) schedule(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("unexpected result transaction at %0t", $realtime);
               mismatch_count++;
            end else begin
               w = expected_rsp.pop_front();
               if (rsp_data.status !== w.status)
                  report("status", 16'(rsp_data.status), 16'(w.status));
               if (rsp_data.ran_tag !== w.ran_tag)
                  report("ran_tag", 16'(rsp_data.ran_tag), 16'(w.ran_tag));
               if (rsp_data.ran_level !== w.ran_level)
                  report("ran_level", 16'(rsp_data.ran_level), 16'(w.ran_level));
               if (rsp_data.finished !== w.finished)
                  report("finished", 16'(rsp_data.finished), 16'(w.finished));
               if (rsp_data.done_tick !== w.done_tick)
                  report("done_tick", rsp_data.done_tick, w.done_tick);
               if (rsp_data.turnaround !== w.turnaround)
                  report("turnaround", rsp_data.turnaround, w.turnaround);
               if (rsp_data.wait_ticks !== w.wait_ticks)
                  report("wait_ticks", rsp_data.wait_ticks, w.wait_ticks);
            end
         end
         pending_count <= expected_rsp.size();
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random arrivals and ticks through the scheduler under
// bursty sending and receiver stalls, with quota changes between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import mlqs_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [0:0] csr_index = CSR_HIGH_QUOTA;
   logic [3:0] csr_wdata = '0;
   int         mismatch_count, pending_count;
   int         burst_left = 0;
   int         stall_mode = 0;

   always #10 clock = ~clock;

   multilevel_queue_scheduler dut (.*);
   mlqs_checker checker_i (.*);

   // receiver stall pattern: phases of always-ready, random and heavy stall
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send(input req_type r);
      @(posedge clock);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      // hold until the edge that takes the transaction
      @(posedge clock iff req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic arrive(input logic [1:0] lvl, input logic [9:0] tag,
                         input logic [3:0] prio, input logic [7:0] svc);
      send('{CMD_ARRIVE, tag, lvl, prio, svc});
   endtask

   task automatic tick();
      req_type r;
      r = $bits(req_type)'($urandom);
      r.cmd = CMD_TICK;
      send(r);
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_quota(input logic [0:0] idx, input logic [3:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      req_type r;
      int      lvl_pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, zero service, bad level, maximum prio
      tick();
      arrive(LEVEL_HIGH, 10'd0, 4'd1, 8'd1);
      arrive(LEVEL_HIGH, 10'd1023, 4'd1, 8'd2);
      arrive(LEVEL_HIGH, 10'd5, 4'd15, 8'd0);
      arrive(LEVEL_MIDDLE, 10'd7, 4'd0, 8'd255);
      arrive(LEVEL_MIDDLE, 10'd8, 4'd10, 8'd3);
      arrive(LEVEL_MIDDLE, 10'd9, 4'd10, 8'd3);
      arrive(LEVEL_LOW, 10'd11, 4'd3, 8'd2);
      arrive(2'd3, 10'h2AA, 4'd5, 8'd5);
      for (int i = 0; i < 16; i++) tick();
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_quota(CSR_HIGH_QUOTA, 4'd0); write_quota(CSR_MIDDLE_QUOTA, 4'd0); end
            1: begin write_quota(CSR_HIGH_QUOTA, 4'd15); write_quota(CSR_MIDDLE_QUOTA, 4'd15); end
            2: begin write_quota(CSR_HIGH_QUOTA, 4'd1); write_quota(CSR_MIDDLE_QUOTA, 4'd1); end
            default: begin
               write_quota(CSR_HIGH_QUOTA, 4'($urandom_range(0, 15)));
               write_quota(CSR_MIDDLE_QUOTA, 4'($urandom_range(0, 15)));
            end
         endcase
         for (int n = 0; n < 200; n++) begin
            r = $bits(req_type)'($urandom);
            // fill bursts in phase 1 so queues overflow; short jobs mostly
            if ($urandom_range(0, 99) < (phase == 1 ? 70 : 45)) begin
               r.cmd = CMD_ARRIVE;
               lvl_pick = $urandom_range(0, 19);
               r.level = (lvl_pick == 0) ? 2'd3 : 2'(lvl_pick % 3);
               if ($urandom_range(0, 9) != 0) r.svc_ticks = 8'($urandom_range(0, 6));
               if ($urandom_range(0, 5) != 0) r.prio = 4'($urandom_range(1, 10));
               send(r);
            end else begin
               tick();
            end
         end
         drain();
      end

      // short mixed run to close out
      write_quota(CSR_HIGH_QUOTA, 4'd3);
      write_quota(CSR_MIDDLE_QUOTA, 4'd2);
      arrive(LEVEL_LOW, 10'd1000, 4'd2, 8'd3);
      arrive(LEVEL_HIGH, 10'd77, 4'd2, 8'd1);
      for (int i = 0; i < 6; i++) tick();
      drain();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("multilevel_queue_scheduler regression: pass");
      end else begin
         $display("multilevel_queue_scheduler regression: fail");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("multilevel_queue_scheduler regression: fail");
      $finish;
   end

endmodule

### filelist.f
hdl/mlqs_pkg.sv
hdl/multilevel_queue_scheduler.sv
tb/mlqs_checker.sv
tb/tb_top.sv
